FILE: design/rme_pkg.sv
// shared types and constants for the rotation matrix to euler block
package rme_pkg;

  localparam int AngW = 28;   // angle accumulator, q.24 with headroom
  localparam int VecW = 27;   // cordic vector width, q.22 with growth room
  localparam int AngTableLen = 24;
  localparam logic signed [AngW-1:0] PiQ24 = 28'sd52707179;
  localparam logic signed [AngW-1:0] RollMax = 28'sd25736;
  localparam logic signed [AngW-1:0] PitchMax = 28'sd12868;

  localparam logic [0:0] ModeZyx = 1'b0;
  localparam logic [0:0] ModeXyz = 1'b1;

  localparam logic [0:0] RegOrderMode = 1'b0;
  localparam logic [0:0] RegLockMargin = 1'b1;

  // pitch saturation codes
  localparam logic [1:0] SatNone = 2'b00;
  localparam logic [1:0] SatPlus = 2'b01;
  localparam logic [1:0] SatMinus = 2'b10;

  // one cordic lane in flight
  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] z;
    logic                   zero;
  } lane_t;

  // per-transaction side data riding along the pipe
  typedef struct packed {
    logic                   valid;
    logic                   locked;
    logic [1:0]             sat;     // pitch saturation code
  } side_t;

  function automatic logic signed [AngW-1:0] atan_entry(input int i);
    logic signed [AngW-1:0] t;
    case (i)
      0: t = 28'sd13176795;  1: t = 28'sd7778716;  2: t = 28'sd4110060;
      3: t = 28'sd2086331;   4: t = 28'sd1047214;  5: t = 28'sd524117;
      6: t = 28'sd262123;    7: t = 28'sd131069;   8: t = 28'sd65536;
      9: t = 28'sd32768;     10: t = 28'sd16384;   11: t = 28'sd8192;
      12: t = 28'sd4096;     13: t = 28'sd2048;    14: t = 28'sd1024;
      15: t = 28'sd512;      16: t = 28'sd256;     17: t = 28'sd128;
      18: t = 28'sd64;       19: t = 28'sd32;      20: t = 28'sd16;
      21: t = 28'sd8;        22: t = 28'sd4;       23: t = 28'sd2;
      default: t = '0;
    endcase
    return t;
  endfunction

  // pre-rotation of cordic: fold left half plane onto the right
  function automatic lane_t lane_start(input logic signed [VecW-1:0] y,
                                       input logic signed [VecW-1:0] x);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      l.z = (y >= 0) ? PiQ24 : -PiQ24;
      l.x = -x;
      l.y = -y;
    end else begin
      l.z = '0;
      l.x = x;
      l.y = y;
    end
    return l;
  endfunction

  function automatic logic signed [15:0] lane_finish(input lane_t l,
                                                     input logic signed [AngW-1:0] lim);
    logic signed [AngW-1:0] r;
    r = (l.z + AngW'(1024)) >>> 11;
    if (l.zero) r = '0;
    else if (r > lim) r = lim;
    else if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

endpackage

FILE: design/rme_sqrt_cell.sv
// one restoring square root step cell for the pitch cosine
module rme_sqrt_cell #(
  parameter int Step = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [47:0] rem_in,
  input  logic [23:0] root_in,
  output logic [47:0] rem_out,
  output logic [23:0] root_out
);
  localparam int Bit = 23 - Step;

  logic [47:0] trial;
  logic [47:0] rem_c;
  logic [23:0] root_c;

  always_comb begin
    // trial = 2*root*2^bit + 2^(2*bit), root holds the bits above this step
    trial = ({24'd0, root_in} << (Bit + 1)) + (48'd1 << (2 * Bit));
    if (rem_in >= trial) begin
      rem_c = rem_in - trial;
      root_c = root_in | (24'd1 << Bit);
    end else begin
      rem_c = rem_in;
      root_c = root_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_c;
      root_out <= root_c;
    end
  end
endmodule

FILE: design/rme_cordic_cell.sv
// one vectoring cordic stage working on three lanes at once
module rme_cordic_cell #(
  parameter int Stage = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  rme_pkg::lane_t lane_in [3],
  input  rme_pkg::side_t side_in,
  output rme_pkg::lane_t lane_out [3],
  output rme_pkg::side_t side_out
);
  import rme_pkg::*;

  localparam int Sh = (Stage < AngTableLen) ? Stage : 0;
  localparam logic Active = (Stage < AngTableLen);

  lane_t nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nxt[k] = lane_in[k];
      if (Active) begin
        if (lane_in[k].y >= 0) begin
          nxt[k].x = lane_in[k].x + (lane_in[k].y >>> Sh);
          nxt[k].y = lane_in[k].y - (lane_in[k].x >>> Sh);
          nxt[k].z = lane_in[k].z + atan_entry(Sh);
        end else begin
          nxt[k].x = lane_in[k].x - (lane_in[k].y >>> Sh);
          nxt[k].y = lane_in[k].y + (lane_in[k].x >>> Sh);
          nxt[k].z = lane_in[k].z - atan_entry(Sh);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) side_out.valid <= 1'b0;
    else if (en) side_out.valid <= side_in.valid;
    if (en) begin
      lane_out <= nxt;
      side_out.locked <= side_in.locked;
      side_out.sat <= side_in.sat;
    end
  end
endmodule

FILE: design/rotation_matrix_to_euler.sv
// top level: rotation matrix to roll, pitch and yaw through a cordic cell chain
//
// input channel: in_valid / in_stall with the eight q2.14 matrix elements;
// a transaction is taken when in_valid is high and in_stall is low.
// output channel: out_valid / out_stall with roll and yaw (q3.13), pitch
// (q2.13) and the gimbal_locked flag.
// config port: cfg_we, cfg_index, cfg_data; index 0 order_mode, 1 lock_margin.
// register path from the accepting edge to the result: the input register,
// 24 square root cells, the cordic cells and the output register.
// throughput: one matrix per cycle, back to back, while results are taken.
// every register of the chain shares one enable; a result held by out_stall
// freezes the whole chain and raises in_stall in the same cycle, so the
// input waits exactly as long as the output does.
// reset clears all valid bits and loads the config defaults (zyx, 164).
module rotation_matrix_to_euler #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] col0_row0,
  input  logic signed [15:0] col0_row1,
  input  logic signed [15:0] col0_row2,
  input  logic signed [15:0] col1_row0,
  input  logic signed [15:0] col1_row1,
  input  logic signed [15:0] col1_row2,
  input  logic signed [15:0] col2_row0,
  input  logic signed [15:0] col2_row2,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle,
  output logic               gimbal_locked,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [14:0]        cfg_data
);
  import rme_pkg::*;

  localparam int SqSteps = 24;

  logic        order_mode;
  logic [14:0] lock_margin;

  // whole chain moves when the output register is empty or being taken
  logic advance;

  assign advance = !out_valid || !out_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= ModeZyx;
      lock_margin <= 15'd164;
    end else if (cfg_we) begin
      case (cfg_index)
        RegOrderMode:  order_mode <= cfg_data[0];
        RegLockMargin: lock_margin <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------- stage 0: operand select, lock test, sqrt radicand ----------
  logic signed [16:0] sinp;
  logic [16:0] mag;
  logic signed [17:0] gap;
  logic [16:0] gap_abs;
  logic locked_c;
  logic signed [33:0] sinp_w;
  logic [33:0] sq;

  always_comb begin
    sinp = order_mode ? -17'(col2_row0) : -17'(col0_row2);
    mag = sinp[16] ? 17'(-sinp) : 17'(sinp);
    gap = $signed({1'b0, mag}) - 18'sd16384;
    gap_abs = gap[17] ? 17'(-gap) : gap[16:0];
    locked_c = gap_abs < {2'b0, lock_margin};
    sinp_w = 34'(sinp);
    sq = 34'(sinp_w * sinp_w);
  end

  side_t s0_side;
  logic signed [16:0] s0_sinp;
  lane_t s0_roll, s0_yaw;
  logic [47:0] s0_rem;

  function automatic logic signed [VecW-1:0] q22(input logic signed [16:0] v);
    return VecW'(v) <<< 8;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) s0_side.valid <= 1'b0;
    else if (advance) s0_side.valid <= in_valid && !in_stall;
    if (advance) begin
      s0_side.locked <= locked_c;
      s0_side.sat <= (sinp >= 17'sd16384) ? SatPlus :
                     (sinp <= -17'sd16384) ? SatMinus : SatNone;
      s0_sinp <= sinp;
      if (locked_c) begin
        s0_roll <= lane_start(order_mode ? q22(17'(col1_row2)) : q22(-17'(col1_row0)),
                              q22(17'(col1_row1)));
      end else begin
        s0_roll <= lane_start(q22(17'(col0_row1)), q22(17'(col0_row0)));
      end
      s0_yaw <= lane_start(q22(17'(col1_row2)), q22(17'(col2_row2)));
      // (2^28 - s*s) << 16; saturated cases give garbage but are overridden
      s0_rem <= 48'({14'd0, 34'h010000000 - sq}) << 16;
    end
  end

  // ---------- square root cell chain; other lanes ride in delay slots ----------
  logic [47:0] sq_rem [SqSteps+1];
  logic [23:0] sq_root [SqSteps+1];
  lane_t d_roll [SqSteps+1];
  lane_t d_yaw [SqSteps+1];
  logic signed [16:0] d_sinp [SqSteps+1];
  side_t d_side [SqSteps+1];

  assign sq_rem[0] = s0_rem;
  assign sq_root[0] = '0;
  assign d_roll[0] = s0_roll;
  assign d_yaw[0] = s0_yaw;
  assign d_sinp[0] = s0_sinp;
  assign d_side[0] = s0_side;

  for (genvar g = 0; g < SqSteps; g++) begin : g_sq
    lane_t roll_q, yaw_q;
    logic signed [16:0] sinp_q;
    side_t side_q;
    rme_sqrt_cell #(.Step(g)) u_cell (
      .clk(clk), .en(advance), .rem_in(sq_rem[g]), .root_in(sq_root[g]),
      .rem_out(sq_rem[g+1]), .root_out(sq_root[g+1])
    );
    always_ff @(posedge clk) begin
      if (rst) side_q.valid <= 1'b0;
      else if (advance) side_q.valid <= d_side[g].valid;
      if (advance) begin
        side_q.locked <= d_side[g].locked;
        side_q.sat <= d_side[g].sat;
        roll_q <= d_roll[g];
        yaw_q <= d_yaw[g];
        sinp_q <= d_sinp[g];
      end
    end
    assign d_roll[g+1] = roll_q;
    assign d_yaw[g+1] = yaw_q;
    assign d_sinp[g+1] = sinp_q;
    assign d_side[g+1] = side_q;
  end

  // ---------- cordic cell chain: roll, yaw and pitch lanes ----------
  lane_t c_lane [CORDIC_STAGES+1][3];
  side_t c_side [CORDIC_STAGES+1];

  assign c_lane[0][0] = d_roll[SqSteps];
  assign c_lane[0][1] = d_yaw[SqSteps];
  assign c_lane[0][2] = lane_start(q22(d_sinp[SqSteps]),
                                   VecW'({1'b0, sq_root[SqSteps]}));
  assign c_side[0] = d_side[SqSteps];

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cd
    rme_cordic_cell #(.Stage(g)) u_cell (
      .clk(clk), .rst(rst), .en(advance),
      .lane_in(c_lane[g]), .side_in(c_side[g]),
      .lane_out(c_lane[g+1]), .side_out(c_side[g+1])
    );
  end

  // ---------- finish and output register ----------
  logic signed [15:0] f_roll, f_yaw;
  logic signed [14:0] f_pitch;
  side_t f_side;
  always_comb begin
    f_side = c_side[CORDIC_STAGES];
    f_roll = lane_finish(c_lane[CORDIC_STAGES][0], RollMax);
    f_yaw = f_side.locked ? '0 : lane_finish(c_lane[CORDIC_STAGES][1], RollMax);
    case (f_side.sat)
      SatPlus:  f_pitch = 15'(PitchMax);
      SatMinus: f_pitch = -15'(PitchMax);
      default:  f_pitch = 15'(lane_finish(c_lane[CORDIC_STAGES][2], PitchMax));
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= f_side.valid;
    if (advance) begin
      roll_angle <= f_roll;
      pitch_angle <= f_pitch;
      yaw_angle <= f_yaw;
      gimbal_locked <= f_side.locked;
    end
  end
endmodule
